[src/rpb_pkg.sv]
// shared types and constants for the rule-30 pixel blend recomposer
// no dependencies; imported by rpb_recompose and the top level
`default_nettype none

package rpb_pkg;

   // one input item: a raster pixel with its row markers
   typedef struct packed {
      logic [7:0] target_pixel;
      logic [7:0] draw_pixel;
      logic       row_start;
      logic       row_end;
      logic       copy_row;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] new_pixel;
      logic       last_of_row;
   } rsp_type;

   // neighborhood handed to the recompose logic
   typedef struct packed {
      logic [7:0] left_final;
      logic [7:0] left_target;
      logic [7:0] centre_draw;
      logic [7:0] centre_target;
      logic [7:0] right_target;
      logic [7:0] right_draw;
   } nbhd_type;

   // row fill state
   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_ONE,
      HELD_TWO
   } held_type;

   // configuration register indexes
   localparam logic CSR_OVERLAY_RATIO = 1'b0;
   localparam logic CSR_BIT_THRESHOLD = 1'b1;

endpackage

`default_nettype wire

[src/rpb_recompose.sv]
// rule-30 recompose of one centre pixel from its three-pixel neighborhood
// depends on rpb_pkg (nbhd_type)
`default_nettype none

module rpb_recompose
   import rpb_pkg::*;
(
   input  wire logic [8:0] overlay_ratio,
   input  wire logic [7:0] bit_threshold,
   input  wire nbhd_type   nbhd,
   output logic      [7:0] new_value
);

   localparam logic [2:0] PAT_BLEND_LO = 3'd1;
   localparam logic [2:0] PAT_BLEND_HI = 3'd4;
   localparam logic [2:0] PAT_KEEP     = 3'd7;

   logic [8:0]  ratio;
   logic [7:0]  blend_l;
   logic [7:0]  blend_c;
   logic [7:0]  blend_r;
   logic [2:0]  pat;
   logic [16:0] scaled;

   function automatic logic [7:0] blend8(input logic [7:0] t, input logic [7:0] d,
                                         input logic [8:0] r);
      logic [16:0] wt;
      logic [16:0] wd;
      logic [16:0] s;
      wt = 17'(t) * 17'(9'd256 - r);
      wd = 17'(d) * 17'(r);
      s  = wt + wd;
      return s[15:8];
   endfunction

   // any ratio with bit 8 set means 1.0
   assign ratio = overlay_ratio[8] ? 9'd256 : overlay_ratio;

   always_comb begin
      blend_l = blend8(nbhd.left_target, nbhd.left_final, ratio);
      blend_c = blend8(nbhd.centre_target, nbhd.centre_draw, ratio);
      blend_r = blend8(nbhd.right_target, nbhd.right_draw, ratio);
      pat     = {blend_l >= bit_threshold, blend_c >= bit_threshold,
                 blend_r >= bit_threshold};
      scaled  = 17'(nbhd.centre_target) * 17'(ratio);
      case (pat) inside
         [PAT_BLEND_LO:PAT_BLEND_HI]: new_value = blend_c;
         PAT_KEEP:                    new_value = nbhd.centre_draw;
         default:                     new_value = scaled[15:8];
      endcase
   end

endmodule

`default_nettype wire

[src/rule30_pixel_blend_recomposer_unit.sv]
// rule-30 pixel blend recomposer, one pixel item accepted per cycle
// latency: a pixel's result is written to a 4-entry result queue at the edge that
// accepts its right neighbor (or the pixel itself when it ends the row) and is
// presented the next cycle when the queue is empty; row ends add a second result that cycle
// throughput: 1 item/cycle; req_stall rises while the queue holds more than 2 items
// reset: synchronous active-high; clears row state and queue, ratio 256, threshold 64
`default_nettype none

module rule30_pixel_blend_recomposer_unit
   import rpb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_data
);

   localparam int unsigned QDEPTH = 4;

   logic [8:0] ratio_ff;
   logic [7:0] thresh_ff;

   held_type   held_ff, held_in, held_mid;
   logic [7:0] left_final_ff, left_final_in;
   logic [7:0] left_target_ff, left_target_in;
   logic [7:0] centre_draw_ff, centre_target_ff;

   nbhd_type   nbhd;
   logic [7:0] recomp_value;
   logic [7:0] mid_value;
   logic       accept, close_old, mid_emit;
   rsp_type    slot0, slot1;
   logic [1:0] push_n;
   logic       pop;

   rsp_type    queue_ff [QDEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] cnt_ff, cnt_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= 9'd256;
         thresh_ff <= 8'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OVERLAY_RATIO: ratio_ff  <= csr_data;
            CSR_BIT_THRESHOLD: thresh_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   assign nbhd = '{left_final:    left_final_ff,
                   left_target:   left_target_ff,
                   centre_draw:   centre_draw_ff,
                   centre_target: centre_target_ff,
                   right_target:  req_data.target_pixel,
                   right_draw:    req_data.draw_pixel};

   rpb_recompose u_recompose (
      .overlay_ratio (ratio_ff),
      .bit_threshold (thresh_ff),
      .nbhd          (nbhd),
      .new_value     (recomp_value)
   );

   // next row state
   always_comb begin
      close_old = req_data.row_start && (held_ff != HELD_NONE);
      held_mid  = close_old ? HELD_NONE : held_ff;
      if (req_data.row_end) begin
         held_in = HELD_NONE;
      end else if (held_mid == HELD_NONE) begin
         held_in = HELD_ONE;
      end else begin
         held_in = HELD_TWO;
      end
   end

   // result items of this pixel, in order
   always_comb begin
      mid_emit  = (held_mid != HELD_NONE);
      mid_value = (held_mid == HELD_TWO && !req_data.copy_row) ? recomp_value
                                                               : centre_draw_ff;
      left_final_in  = mid_emit ? mid_value : left_final_ff;
      left_target_in = mid_emit ? centre_target_ff : left_target_ff;
      slot1 = '{new_pixel: req_data.draw_pixel, last_of_row: 1'b1};
      if (close_old) begin
         slot0  = '{new_pixel: centre_draw_ff, last_of_row: 1'b1};
         push_n = req_data.row_end ? 2'd2 : 2'd1;
      end else if (mid_emit) begin
         slot0  = '{new_pixel: mid_value, last_of_row: 1'b0};
         push_n = req_data.row_end ? 2'd2 : 2'd1;
      end else begin
         slot0  = slot1;
         push_n = req_data.row_end ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_final_ff    <= 8'd0;
         left_target_ff   <= 8'd0;
         centre_draw_ff   <= 8'd0;
         centre_target_ff <= 8'd0;
      end else if (accept) begin
         left_final_ff    <= left_final_in;
         left_target_ff   <= left_target_in;
         centre_draw_ff   <= req_data.draw_pixel;
         centre_target_ff <= req_data.target_pixel;
      end
   end

   // result queue, up to two writes and one read per cycle
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > 3'(QDEPTH - 2));
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff + (accept ? 3'(push_n) : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (accept && push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (accept && push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + push_n;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH))
      else $error("result queue overflow");

   a_row_closed: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.row_end |=> held_ff == HELD_NONE)
      else $error("row still open after row end");

   a_row_open: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.row_end |=> held_ff != HELD_NONE)
      else $error("row not open after pixel");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> cnt_ff <= $past(cnt_ff))
      else $error("queue grew without an accepted item");
`endif

endmodule

`default_nettype wire

[tb/rpb_recompose_checker.sv]
// checker for the rule-30 pixel blend recomposer: watches the pixel, result and
// register channels, predicts each result item and compares it field by field
// depends on rpb_pkg for the item types, the row fill states and the register indexes
`default_nettype none

module rpb_recompose_checker
   import rpb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_data,
   output int              pending_count,
   output int              checked_count,
   output int              error_count
);

   localparam int PRINT_LIMIT = 40;

   logic [8:0] ratio_q;
   logic [7:0] threshold_q;
   held_type   held;
   logic [7:0] left_final_q;
   logic [7:0] left_target_q;
   logic [7:0] centre_draw_q;
   logic [7:0] centre_target_q;
   rsp_type    expected_pixels[$];
   rsp_type    oldest;

   // ratios above one act as one
   function automatic logic [8:0] clipped_ratio();
      return (ratio_q > 9'd256) ? 9'd256 : ratio_q;
   endfunction

   function automatic logic [7:0] mix(input logic [7:0] t, input logic [7:0] d);
      logic [17:0] acc;
      logic [8:0]  r;
      r   = clipped_ratio();
      acc = t * (18'd256 - r) + d * r;
      return acc[15:8];
   endfunction

   function automatic logic [7:0] recompose(input logic [7:0] rt, input logic [7:0] rd);
      logic [7:0]  centre_mix;
      logic [16:0] scaled;
      logic        l, c, r;
      centre_mix = mix(centre_target_q, centre_draw_q);
      l = mix(left_target_q, left_final_q) >= threshold_q;
      c = centre_mix >= threshold_q;
      r = mix(rt, rd) >= threshold_q;
      scaled = centre_target_q * clipped_ratio();
      // all three set keeps the draw value, else rule 30 picks blend or scaled target
      if (l && c && r)
         return centre_draw_q;
      else if (l ^ (c | r))
         return centre_mix;
      else
         return scaled[15:8];
   endfunction

   task automatic queue_pixel(input logic [7:0] value, input logic last);
      rsp_type item;
      item.new_pixel   = value;
      item.last_of_row = last;
      expected_pixels.push_back(item);
   endtask

   task automatic predict_pixel(input req_type px);
      logic [7:0] value;
      // a row start closes an unterminated row
      if (px.row_start && held != HELD_NONE) begin
         queue_pixel(centre_draw_q, 1'b1);
         held = HELD_NONE;
      end
      case (held)
         HELD_NONE: begin
            held = HELD_ONE;
         end
         HELD_ONE: begin
            queue_pixel(centre_draw_q, 1'b0);
            left_final_q  = centre_draw_q;
            left_target_q = centre_target_q;
            held          = HELD_TWO;
         end
         default: begin
            value = px.copy_row ? centre_draw_q : recompose(px.target_pixel, px.draw_pixel);
            queue_pixel(value, 1'b0);
            left_final_q  = value;
            left_target_q = centre_target_q;
            held          = HELD_TWO;
         end
      endcase
      centre_draw_q   = px.draw_pixel;
      centre_target_q = px.target_pixel;
      if (px.row_end) begin
         queue_pixel(px.draw_pixel, 1'b1);
         held = HELD_NONE;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s, got %0d want %0d (result item %0d)",
                  $time, what, got, want, checked_count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ratio_q         = 9'd256;
         threshold_q     = 8'd64;
         held            = HELD_NONE;
         left_final_q    = '0;
         left_target_q   = '0;
         centre_draw_q   = '0;
         centre_target_q = '0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OVERLAY_RATIO)
               ratio_q = csr_data;
            else
               threshold_q = csr_data[7:0];
         end
         if (req_valid && !req_stall)
            predict_pixel(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("result item with nothing expected",
                               int'(rsp_data.new_pixel), 0);
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_data.new_pixel !== oldest.new_pixel)
                  report_mismatch("new_pixel", int'(rsp_data.new_pixel),
                                  int'(oldest.new_pixel));
               if (rsp_data.last_of_row !== oldest.last_of_row)
                  report_mismatch("last_of_row", int'(rsp_data.last_of_row),
                                  int'(oldest.last_of_row));
            end
            checked_count++;
         end
      end
      pending_count <= expected_pixels.size();
   end

endmodule

`default_nettype wire

[tb/tb_rule30_pixel_blend_recomposer_unit.sv]
// testbench top for rule30_pixel_blend_recomposer_unit: clock, reset, pixel rows,
// register writes and random stalls; the verdict comes from rpb_recompose_checker
// depends on rpb_pkg, the block and the checker
`default_nettype none

module tb_rule30_pixel_blend_recomposer_unit;
   import rpb_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASE_ITEMS  = 165;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_OVERLAY_RATIO;
   logic [8:0] csr_data  = '0;

   int pending_count;
   int checked_count;
   int error_count;

   int         items_sent    = 0;
   int         rows_sent     = 0;
   int         csr_writes    = 0;
   int         stall_left    = 0;
   bit         steady_req    = 1'b0;
   bit         steady_rsp    = 1'b0;
   logic [7:0] cur_threshold = 8'd64;

   logic [8:0] ratio_table [7]     = '{9'd0, 9'd511, 9'd256, 9'd1, 9'd255, 9'd257, 9'd128};
   logic [7:0] threshold_table [7] = '{8'd255, 8'd0, 8'd64, 8'd1, 8'd254, 8'd128, 8'd32};

   rule30_pixel_blend_recomposer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rpb_recompose_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .error_count   (error_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10000000;
      $display("FAIL rule30_pixel_blend_recomposer_unit");
      $finish;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (!steady_rsp && $urandom_range(0, 3) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = idle_len() - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // called and returns at a falling edge; valid stays high for a following item
   task automatic send_pixel(input logic [7:0] t, input logic [7:0] d,
                             input logic rs, input logic re, input logic cp);
      int gap;
      gap = (!steady_req && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid             = 1'b1;
      req_data.target_pixel = t;
      req_data.draw_pixel   = d;
      req_data.row_start    = rs;
      req_data.row_end      = re;
      req_data.copy_row     = cp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every expected item, then let a held pixel settle
   task automatic settle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [8:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
      if (idx == CSR_BIT_THRESHOLD)
         cur_threshold = value[7:0];
   endtask

   // extremes, values around the threshold, or anything
   function automatic logic [7:0] pick_value();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 2)
         return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      if (r < 5) begin
         v = int'(cur_threshold) + int'($urandom_range(0, 8)) - 4;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         return v[7:0];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_row();
      int   style;
      int   len;
      logic cp;
      logic rs;
      logic re;
      style = $urandom_range(0, 99);
      len   = (style < 5) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      cp    = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
         if (style >= 90) begin
            // noise: markers at random
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                       1'($urandom_range(0, 1)));
         end else begin
            rs = (i == 0) && !(style >= 85 && style < 90);
            re = (i == len - 1) && !(style >= 80 && style < 85);
            send_pixel(pick_value(), pick_value(), rs, re, cp);
         end
      end
      rows_sent++;
   endtask

   initial begin
      int         p;
      int         random_start;
      int         phase_start;
      bit         paused;
      logic [8:0] ratio_pick;
      logic [7:0] thr_pick;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pixels before any row start, then a row left open and closed by a new start
      send_pixel(8'd10, 8'd200, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd20, 8'd100, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd30, 8'd50, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
      // one-pixel row
      send_pixel(8'd255, 8'd0, 1'b1, 1'b1, 1'b0);
      // field extremes at reset settings
      send_pixel(8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd128, 8'd64, 1'b0, 1'b1, 1'b0);
      // copied row
      send_pixel(8'd1, 8'd254, 1'b1, 1'b0, 1'b1);
      send_pixel(8'd200, 8'd3, 1'b0, 1'b0, 1'b1);
      send_pixel(8'd77, 8'd99, 1'b0, 1'b0, 1'b1);
      send_pixel(8'd5, 8'd250, 1'b0, 1'b1, 1'b1);
      // ratio above one, top threshold
      settle();
      write_csr(CSR_OVERLAY_RATIO, 9'd511);
      write_csr(CSR_BIT_THRESHOLD, 9'd255);
      send_pixel(8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd100, 8'd255, 1'b0, 1'b1, 1'b0);
      // draw weight zero, threshold zero
      settle();
      write_csr(CSR_OVERLAY_RATIO, 9'd0);
      write_csr(CSR_BIT_THRESHOLD, 9'd0);
      send_pixel(8'd200, 8'd17, 1'b1, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd9, 1'b0, 1'b1, 1'b0);

      random_start = items_sent;
      paused       = 1'b0;
      p            = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         settle();
         ratio_pick = (p < 7) ? ratio_table[p] : 9'($urandom_range(0, 511));
         thr_pick   = (p < 7) ? threshold_table[p] : 8'($urandom_range(0, 255));
         write_csr(CSR_OVERLAY_RATIO, ratio_pick);
         write_csr(CSR_BIT_THRESHOLD, {1'b0, thr_pick});
         steady_req  = (p % 3 == 1);
         steady_rsp  = (p % 4 == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_random_row();
            if (p == 3 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
               // hold off until the block has drained
               req_valid = 1'b0;
               while (pending_count != 0) @(negedge clock);
               paused = 1'b1;
            end
         end
         p++;
      end

      steady_req = 1'b0;
      settle();
      repeat (20) @(negedge clock);
      $display("sent %0d pixel items in %0d rows, %0d register writes over %0d random phases",
               items_sent, rows_sent, csr_writes, p);
      $display("compared %0d result items, %0d mismatches", checked_count, error_count);
      if (error_count == 0 && pending_count == 0)
         $display("PASS rule30_pixel_blend_recomposer_unit");
      else
         $display("FAIL rule30_pixel_blend_recomposer_unit");
      $finish;
   end

endmodule

`default_nettype wire
